// File: hw/rtl/midi_note_pair_reverser_unit_macros.svh
// Assertion macros used by the note pair reverser top level.
`ifndef MIDI_NOTE_PAIR_REVERSER_UNIT_MACROS_SVH
`define MIDI_NOTE_PAIR_REVERSER_UNIT_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define MNPR_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Check a consequence in the same cycle as its cause.
`define MNPR_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Check a consequence in the cycle after its cause.
`define MNPR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: hw/rtl/mnpr_pkg.sv
// Shared types and constants of the note pair reverser.
package mnpr_pkg;

  // Command codes
  localparam logic [1:0] CMD_APPEND  = 2'd0;
  localparam logic [1:0] CMD_REVERSE = 2'd1;
  localparam logic [1:0] CMD_READ    = 2'd2;
  localparam logic [1:0] CMD_CLEAR   = 2'd3;

  // Result status codes
  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_FULL  = 2'd1;
  localparam logic [1:0] STAT_EMPTY = 2'd2;
  localparam logic [1:0] STAT_RANGE = 2'd3;

  // MIDI message kinds
  localparam logic [7:0] KIND_MASK     = 8'hF0;
  localparam logic [7:0] KIND_NOTE_ON  = 8'h90;
  localparam logic [7:0] KIND_NOTE_OFF = 8'h80;

  localparam int NUM_CHANNELS = 16;
  localparam int NUM_NOTES    = 128;
  localparam int SLOTS        = NUM_CHANNELS * NUM_NOTES;
  localparam int SLOT_W       = $clog2(SLOTS);
  localparam int TIME_W       = 48;
  localparam int CNT_OUT_W    = 11;
  localparam int EPOCH_W      = 8;

  // Stored message word, status byte in the low bits
  typedef struct packed {
    logic [1:0] len;
    logic [7:0] d2;
    logic [7:0] d1;
    logic [7:0] st;
  } ev_word_t;

  // Event store port controls
  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic wr_time;
  } evm_ctl_t;

  // Pending table port controls
  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } pend_ctl_t;

  // Pending table slot: channel and low seven bits of the note number
  function automatic logic [SLOT_W-1:0] slot_of(ev_word_t w);
    return {w.st[3:0], w.d1[6:0]};
  endfunction

endpackage

// File: hw/rtl/midi_note_pair_reverser_unit.sv
// Top level of the note pair reverser: command sequencer, store and pending table.
//
//   channel | handshake            | payload
//   --------+----------------------+---------------------------------------------
//   in      | in_valid / in_ready  | cmd, timestamp, status_byte, data_one,
//           |                      | data_two, msg_len, entry_index
//   out     | out_valid / out_ready| status_code, ev_*, swap_count, dup_on_count,
//           |                      | orphan_off_count, is_reversed, entry_count
//
// Append, read, clear and reverse on an empty store go from idle to the finish state.
// A reverse pass visits the look and act states per stored entry, then finishes;
// a swapped pair adds the swap states S_SWA and S_SWB. Reset clears the pending table;
// the same sweep runs before one reverse pass in every 255, when the epoch tag wraps.
// in_ready is high only when the sequencer is idle; a finished beat waits in
// the output register while out_ready is low, and the next item may still enter.
module midi_note_pair_reverser_unit #(
  parameter int MAX_EVENTS = 1024
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic [1:0]                             cmd,
  input  logic [47:0]                            timestamp,
  input  logic [7:0]                             status_byte,
  input  logic [7:0]                             data_one,
  input  logic [7:0]                             data_two,
  input  logic [1:0]                             msg_len,
  input  logic [9:0]                             entry_index,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic [1:0]                             status_code,
  output logic [47:0]                            ev_timestamp,
  output logic [7:0]                             ev_status,
  output logic [7:0]                             ev_data_one,
  output logic [7:0]                             ev_data_two,
  output logic [1:0]                             ev_len,
  output logic [10:0]                            swap_count,
  output logic [10:0]                            dup_on_count,
  output logic [10:0]                            orphan_off_count,
  output logic                                   is_reversed,
  output logic [10:0]                            entry_count
);

  localparam int CW   = $clog2(MAX_EVENTS + 1);
  localparam int IW   = $clog2(MAX_EVENTS);
  localparam int CMPW = ((CW > 10) ? CW : 10) + 1;
  localparam int EW   = mnpr_pkg::EPOCH_W;
  localparam int SW   = mnpr_pkg::SLOT_W;
  localparam int OW   = mnpr_pkg::CNT_OUT_W;

  // Sequencer states
  localparam logic [2:0] S_SWEEP = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_FIN   = 3'd2;
  localparam logic [2:0] S_LOOK  = 3'd3;
  localparam logic [2:0] S_ACT   = 3'd4;
  localparam logic [2:0] S_SWA   = 3'd5;
  localparam logic [2:0] S_SWB   = 3'd6;

  logic [2:0]               state;
  logic [CW-1:0]            count;
  logic                     rev;
  logic [EW-1:0]            epoch;
  logic [SW-1:0]            sweep_addr;
  logic                     in_pass;
  logic [1:0]               cmd_r;
  logic [1:0]               stat_r;
  logic [IW-1:0]            idx;
  logic [CW-1:0]            rem;
  mnpr_pkg::ev_word_t       cur_w;
  logic [OW-1:0]            swaps;
  logic [OW-1:0]            dups;
  logic [OW-1:0]            orphans;

  logic                     in_fire;
  logic                     full;
  logic                     out_free;
  logic                     sweep_done;
  logic                     last;
  logic [CMPW-1:0]          ext_index;
  logic [CMPW-1:0]          ext_count;
  logic                     read_ok;
  logic [IW-1:0]            start_idx;
  logic [IW-1:0]            next_idx;
  logic [1:0]               app_len;
  mnpr_pkg::ev_word_t       app_word;
  logic                     cur_on;
  logic                     cur_off;

  mnpr_pkg::evm_ctl_t       evm_ctl;
  logic [IW-1:0]            ev_wr_addr;
  mnpr_pkg::ev_word_t       ev_wr_word;
  logic [IW-1:0]            ev_rd_addr;
  logic [47:0]              ev_rd_time;
  mnpr_pkg::ev_word_t       ev_rd_word;

  mnpr_pkg::pend_ctl_t      pend_ctl;
  logic [SW-1:0]            pend_wr_addr;
  logic [EW-1:0]            pend_wr_tag;
  logic [SW-1:0]            pend_rd_addr;
  logic                     pend_hit;
  logic [IW-1:0]            pend_idx;

  mnpr_event_mem #(.DEPTH(MAX_EVENTS), .AW(IW)) u_event_mem (
    .clk     (clk),
    .ctl     (evm_ctl),
    .wr_addr (ev_wr_addr),
    .wr_time (timestamp),
    .wr_word (ev_wr_word),
    .rd_addr (ev_rd_addr),
    .rd_time (ev_rd_time),
    .rd_word (ev_rd_word)
  );

  mnpr_pend_table #(.IW(IW)) u_pend_table (
    .clk     (clk),
    .ctl     (pend_ctl),
    .wr_addr (pend_wr_addr),
    .wr_tag  (pend_wr_tag),
    .wr_idx  (idx),
    .rd_addr (pend_rd_addr),
    .epoch   (epoch),
    .rd_hit  (pend_hit),
    .rd_idx  (pend_idx)
  );

  // Decode handshake and shared compares
  assign in_ready   = (state == S_IDLE);
  assign in_fire    = in_valid && in_ready;
  assign out_free   = !out_valid || out_ready;
  assign full       = (count == CW'(MAX_EVENTS));
  assign sweep_done = (sweep_addr == SW'(mnpr_pkg::SLOTS - 1));
  assign last       = (rem == CW'(1));
  assign ext_index  = {{(CMPW-10){1'b0}}, entry_index};
  assign ext_count  = {{(CMPW-CW){1'b0}}, count};
  assign read_ok    = (ext_index < ext_count);
  assign start_idx  = rev ? IW'(count - CW'(1)) : '0;
  assign next_idx   = rev ? (idx - IW'(1)) : (idx + IW'(1));

  // Build the appended word; a zero length counts as one byte
  always_comb begin
    app_len     = (msg_len == 2'd0) ? 2'd1 : msg_len;
    app_word.st = status_byte;
    app_word.d1 = (app_len >= 2'd2) ? data_one : 8'd0;
    app_word.d2 = (app_len == 2'd3) ? data_two : 8'd0;
    app_word.len = app_len;
  end

  assign cur_on  = ((cur_w.st & mnpr_pkg::KIND_MASK) == mnpr_pkg::KIND_NOTE_ON);
  assign cur_off = ((cur_w.st & mnpr_pkg::KIND_MASK) == mnpr_pkg::KIND_NOTE_OFF);

  // Drive memory ports from the sequencer state
  always_comb begin
    evm_ctl      = '0;
    ev_wr_addr   = idx;
    ev_wr_word   = app_word;
    ev_rd_addr   = idx;
    pend_ctl     = '0;
    pend_wr_addr = mnpr_pkg::slot_of(cur_w);
    pend_wr_tag  = '0;
    pend_rd_addr = mnpr_pkg::slot_of(ev_rd_word);
    case (state)
      S_SWEEP: begin
        pend_ctl.wr_en = 1'b1;
        pend_wr_addr   = sweep_addr;
        if (sweep_done && in_pass) begin
          evm_ctl.rd_en = 1'b1;
        end
      end
      S_IDLE: begin
        if (in_fire) begin
          case (cmd)
            mnpr_pkg::CMD_APPEND: begin
              if (!full) begin
                evm_ctl.wr_en   = 1'b1;
                evm_ctl.wr_time = 1'b1;
                ev_wr_addr      = count[IW-1:0];
              end
            end
            mnpr_pkg::CMD_READ: begin
              evm_ctl.rd_en = 1'b1;
              ev_rd_addr    = ext_index[IW-1:0];
            end
            mnpr_pkg::CMD_REVERSE: begin
              if (count != '0) begin
                evm_ctl.rd_en = 1'b1;
                ev_rd_addr    = start_idx;
              end
            end
            default: ;
          endcase
        end
      end
      S_LOOK: begin
        pend_ctl.rd_en = 1'b1;
      end
      S_ACT: begin
        if (cur_on && !pend_hit) begin
          pend_ctl.wr_en = 1'b1;
          pend_wr_tag    = epoch;
        end else if (cur_off && pend_hit) begin
          evm_ctl.rd_en = 1'b1;
          ev_rd_addr    = pend_idx;
        end else if (!last) begin
          evm_ctl.rd_en = 1'b1;
          ev_rd_addr    = next_idx;
        end
        if (cur_on && !pend_hit && !last) begin
          evm_ctl.rd_en = 1'b1;
          ev_rd_addr    = next_idx;
        end
      end
      S_SWA: begin
        evm_ctl.wr_en = 1'b1;
        ev_wr_addr    = pend_idx;
        ev_wr_word    = ev_rd_word;
        ev_wr_word.st = cur_w.st;
      end
      S_SWB: begin
        evm_ctl.wr_en  = 1'b1;
        ev_wr_addr     = idx;
        ev_wr_word     = cur_w;
        ev_wr_word.st  = ev_rd_word.st;
        pend_ctl.wr_en = 1'b1;
        if (!last) begin
          evm_ctl.rd_en = 1'b1;
          ev_rd_addr    = next_idx;
        end
      end
      default: ;
    endcase
  end

  // Advance the sequencer and the store state
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_SWEEP;
      count      <= '0;
      rev        <= 1'b0;
      epoch      <= '0;
      sweep_addr <= '0;
      in_pass    <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (out_valid && out_ready && state != S_FIN) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_SWEEP: begin
          sweep_addr <= sweep_addr + SW'(1);
          if (sweep_done) begin
            if (in_pass) begin
              epoch <= EW'(1);
              state <= S_LOOK;
            end else begin
              epoch <= '0;
              state <= S_IDLE;
            end
          end
        end
        S_IDLE: begin
          if (in_fire) begin
            cmd_r   <= cmd;
            stat_r  <= mnpr_pkg::STAT_OK;
            swaps   <= '0;
            dups    <= '0;
            orphans <= '0;
            state   <= S_FIN;
            case (cmd)
              mnpr_pkg::CMD_APPEND: begin
                if (full) begin
                  stat_r <= mnpr_pkg::STAT_FULL;
                end else begin
                  count <= count + CW'(1);
                end
              end
              mnpr_pkg::CMD_READ: begin
                if (!read_ok) begin
                  stat_r <= mnpr_pkg::STAT_RANGE;
                end
              end
              mnpr_pkg::CMD_REVERSE: begin
                if (count == '0) begin
                  stat_r <= mnpr_pkg::STAT_EMPTY;
                end else begin
                  idx <= start_idx;
                  rem <= count;
                  if (epoch == '1) begin
                    in_pass    <= 1'b1;
                    sweep_addr <= '0;
                    state      <= S_SWEEP;
                  end else begin
                    epoch <= epoch + EW'(1);
                    state <= S_LOOK;
                  end
                end
              end
              default: begin
                count <= '0;
                rev   <= 1'b0;
              end
            endcase
          end
        end
        S_FIN: begin
          if (out_free) begin
            out_valid        <= 1'b1;
            status_code      <= stat_r;
            swap_count       <= swaps;
            dup_on_count     <= dups;
            orphan_off_count <= orphans;
            is_reversed      <= rev;
            entry_count      <= ext_count[OW-1:0];
            if (cmd_r == mnpr_pkg::CMD_READ && stat_r == mnpr_pkg::STAT_OK) begin
              ev_timestamp <= ev_rd_time;
              ev_status    <= ev_rd_word.st;
              ev_data_one  <= ev_rd_word.d1;
              ev_data_two  <= ev_rd_word.d2;
              ev_len       <= ev_rd_word.len;
            end else begin
              ev_timestamp <= '0;
              ev_status    <= '0;
              ev_data_one  <= '0;
              ev_data_two  <= '0;
              ev_len       <= '0;
            end
            state <= S_IDLE;
          end
        end
        S_LOOK: begin
          cur_w   <= ev_rd_word;
          in_pass <= 1'b0;
          state   <= S_ACT;
        end
        S_ACT: begin
          if (cur_off && pend_hit) begin
            state <= S_SWA;
          end else begin
            if (cur_on && pend_hit) begin
              dups <= dups + OW'(1);
            end
            if (cur_off && !pend_hit) begin
              orphans <= orphans + OW'(1);
            end
            if (last) begin
              rev   <= !rev;
              state <= S_FIN;
            end else begin
              idx   <= next_idx;
              rem   <= rem - CW'(1);
              state <= S_LOOK;
            end
          end
        end
        S_SWA: begin
          state <= S_SWB;
        end
        S_SWB: begin
          swaps <= swaps + OW'(1);
          if (last) begin
            rev   <= !rev;
            state <= S_FIN;
          end else begin
            idx   <= next_idx;
            rem   <= rem - CW'(1);
            state <= S_LOOK;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `include "midi_note_pair_reverser_unit_macros.svh"

  `MNPR_ASSERT_ALWAYS(a_count_cap, count <= CW'(MAX_EVENTS), "store count above capacity")
  `MNPR_ASSERT_IMPLY(a_walk_in_range, state == S_ACT, CW'(idx) < count, "walk index past store end")
  `MNPR_ASSERT_IMPLY(a_epoch_live, state == S_LOOK || state == S_ACT, epoch != '0, "pass uses cleared epoch")
  `MNPR_ASSERT_NEXT(a_swap_two_step, state == S_SWA, state == S_SWB, "swap did not finish")
  `MNPR_ASSERT_NEXT(a_fin_holds, state == S_FIN && out_valid && !out_ready, state == S_FIN && out_valid, "finished beat dropped while output stalled")

endmodule

// File: hw/rtl/mnpr_event_mem.sv
// Event store: timestamp and message word memories, one write and one read port.
module mnpr_event_mem #(
  parameter int DEPTH = 1024,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                          clk,
  input  mnpr_pkg::evm_ctl_t            ctl,
  input  logic [AW-1:0]                 wr_addr,
  input  logic [mnpr_pkg::TIME_W-1:0]   wr_time,
  input  mnpr_pkg::ev_word_t            wr_word,
  input  logic [AW-1:0]                 rd_addr,
  output logic [mnpr_pkg::TIME_W-1:0]   rd_time,
  output mnpr_pkg::ev_word_t            rd_word
);

  logic [mnpr_pkg::TIME_W-1:0] time_mem [DEPTH];
  mnpr_pkg::ev_word_t          word_mem [DEPTH];

  // Write on request; register read data and hold it between reads
  always_ff @(posedge clk) begin
    if (ctl.wr_en && ctl.wr_time) begin
      time_mem[wr_addr] <= wr_time;
    end
    if (ctl.wr_en) begin
      word_mem[wr_addr] <= wr_word;
    end
    if (ctl.rd_en) begin
      rd_time <= time_mem[rd_addr];
      rd_word <= word_mem[rd_addr];
    end
  end

endmodule

// File: hw/rtl/mnpr_pend_table.sv
// Pending note-on table: per slot an epoch tag and the store index of the note-on.
module mnpr_pend_table #(
  parameter int IW = 10
) (
  input  logic                          clk,
  input  mnpr_pkg::pend_ctl_t           ctl,
  input  logic [mnpr_pkg::SLOT_W-1:0]   wr_addr,
  input  logic [mnpr_pkg::EPOCH_W-1:0]  wr_tag,
  input  logic [IW-1:0]                 wr_idx,
  input  logic [mnpr_pkg::SLOT_W-1:0]   rd_addr,
  input  logic [mnpr_pkg::EPOCH_W-1:0]  epoch,
  output logic                          rd_hit,
  output logic [IW-1:0]                 rd_idx
);

  logic [mnpr_pkg::EPOCH_W+IW-1:0] pend_mem [mnpr_pkg::SLOTS];
  logic [mnpr_pkg::EPOCH_W-1:0]    rd_tag;

  // Write on request; register read data
  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      pend_mem[wr_addr] <= {wr_tag, wr_idx};
    end
    if (ctl.rd_en) begin
      {rd_tag, rd_idx} <= pend_mem[rd_addr];
    end
  end

  // An entry is pending only if it was written in the current pass
  assign rd_hit = (rd_tag == epoch);

endmodule

// File: verif/tb_midi_note_pair_reverser_unit.sv
// Testbench of the note pair reverser: directed command table, random command streams, then a full store.
module tb_midi_note_pair_reverser_unit;

  localparam int STORE_DEPTH  = 1024;
  localparam int IDLE_LIMIT   = 20000;
  localparam int DRAIN_CYCLES = 40;
  localparam int RANDOM_ITEMS = 240;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [47:0] ts;
    logic [7:0]  st;
    logic [7:0]  d1;
    logic [7:0]  d2;
    logic [1:0]  len;
    logic [9:0]  idx;
  } note_cmd_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [47:0] ts;
    logic [7:0]  st;
    logic [7:0]  d1;
    logic [7:0]  d2;
    logic [1:0]  len;
    logic [10:0] swaps;
    logic [10:0] dups;
    logic [10:0] orphans;
    logic        rev;
    logic [10:0] count;
  } note_result_t;

  typedef struct packed {
    note_cmd_t    c;
    logic         has_exp;
    note_result_t r;
  } dir_row_t;

  localparam note_result_t NO_RESULT = '0;

  logic        clk;
  logic        rst         = 1'b1;
  logic        in_valid    = 1'b0;
  logic [1:0]  cmd         = '0;
  logic [47:0] timestamp   = '0;
  logic [7:0]  status_byte = '0;
  logic [7:0]  data_one    = '0;
  logic [7:0]  data_two    = '0;
  logic [1:0]  msg_len     = '0;
  logic [9:0]  entry_index = '0;
  logic        out_ready   = 1'b0;

  logic        in_ready;
  logic        out_valid;
  logic [1:0]  status_code;
  logic [47:0] ev_timestamp;
  logic [7:0]  ev_status;
  logic [7:0]  ev_data_one;
  logic [7:0]  ev_data_two;
  logic [1:0]  ev_len;
  logic [10:0] swap_count;
  logic [10:0] dup_on_count;
  logic [10:0] orphan_off_count;
  logic        is_reversed;
  logic [10:0] entry_count;

  midi_note_pair_reverser_unit #(
    .MAX_EVENTS(STORE_DEPTH)
  ) i_dut (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .cmd              (cmd),
    .timestamp        (timestamp),
    .status_byte      (status_byte),
    .data_one         (data_one),
    .data_two         (data_two),
    .msg_len          (msg_len),
    .entry_index      (entry_index),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .status_code      (status_code),
    .ev_timestamp     (ev_timestamp),
    .ev_status        (ev_status),
    .ev_data_one      (ev_data_one),
    .ev_data_two      (ev_data_two),
    .ev_len           (ev_len),
    .swap_count       (swap_count),
    .dup_on_count     (dup_on_count),
    .orphan_off_count (orphan_off_count),
    .is_reversed      (is_reversed),
    .entry_count      (entry_count)
  );

  // Shadow copy of the event store and the pending note-on table
  logic [47:0] shadow_time [0:STORE_DEPTH-1];
  logic [7:0]  shadow_st   [0:STORE_DEPTH-1];
  logic [7:0]  shadow_d1   [0:STORE_DEPTH-1];
  logic [7:0]  shadow_d2   [0:STORE_DEPTH-1];
  logic [1:0]  shadow_n    [0:STORE_DEPTH-1];
  logic        open_valid  [0:mnpr_pkg::SLOTS-1];
  logic [9:0]  open_at     [0:mnpr_pkg::SLOTS-1];
  int          shadow_count = 0;
  logic        shadow_flip  = 1'b0;

  note_result_t due_results [$];
  int           mismatch_count = 0;
  bit           calm = 1'b0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Apply one command to the shadow state and return the beat it must produce
  function automatic note_result_t apply_command(note_cmd_t c);
    note_result_t r;
    int k;
    int at;
    int other;
    logic [mnpr_pkg::SLOT_W-1:0] slot;
    logic [7:0] held;
    r = '0;
    case (c.cmd)
      mnpr_pkg::CMD_APPEND: begin
        if (shadow_count >= STORE_DEPTH) begin
          r.status = mnpr_pkg::STAT_FULL;
        end else begin
          shadow_time[shadow_count] = c.ts;
          shadow_st[shadow_count]   = c.st;
          shadow_d1[shadow_count]   = (c.len >= 2'd2) ? c.d1 : 8'h00;
          shadow_d2[shadow_count]   = (c.len == 2'd3) ? c.d2 : 8'h00;
          shadow_n[shadow_count]    = (c.len == 2'd0) ? 2'd1 : c.len;
          shadow_count++;
        end
      end
      mnpr_pkg::CMD_REVERSE: begin
        if (shadow_count == 0) begin
          r.status = mnpr_pkg::STAT_EMPTY;
        end else begin
          for (k = 0; k < mnpr_pkg::SLOTS; k++) open_valid[k] = 1'b0;
          // Walk forward, or backward when already flipped
          for (k = 0; k < shadow_count; k++) begin
            at   = shadow_flip ? shadow_count - 1 - k : k;
            slot = {shadow_st[at][3:0], shadow_d1[at][6:0]};
            if ((shadow_st[at] & mnpr_pkg::KIND_MASK) == mnpr_pkg::KIND_NOTE_ON) begin
              if (open_valid[slot]) begin
                r.dups = r.dups + 11'd1;
              end else begin
                open_valid[slot] = 1'b1;
                open_at[slot]    = at[9:0];
              end
            end else if ((shadow_st[at] & mnpr_pkg::KIND_MASK) == mnpr_pkg::KIND_NOTE_OFF) begin
              if (open_valid[slot]) begin
                other            = int'(open_at[slot]);
                held             = shadow_st[other];
                shadow_st[other] = shadow_st[at];
                shadow_st[at]    = held;
                open_valid[slot] = 1'b0;
                r.swaps          = r.swaps + 11'd1;
              end else begin
                r.orphans = r.orphans + 11'd1;
              end
            end
          end
          shadow_flip = !shadow_flip;
        end
      end
      mnpr_pkg::CMD_READ: begin
        if (int'(c.idx) >= shadow_count) begin
          r.status = mnpr_pkg::STAT_RANGE;
        end else begin
          r.ts  = shadow_time[c.idx];
          r.st  = shadow_st[c.idx];
          r.d1  = shadow_d1[c.idx];
          r.d2  = shadow_d2[c.idx];
          r.len = shadow_n[c.idx];
        end
      end
      default: begin
        shadow_count = 0;
        shadow_flip  = 1'b0;
      end
    endcase
    r.rev   = shadow_flip;
    r.count = shadow_count[10:0];
    return r;
  endfunction

  function automatic note_cmd_t mk_cmd(logic [1:0] op, logic [47:0] ts, logic [7:0] st,
                                       logic [7:0] d1, logic [7:0] d2, logic [1:0] len,
                                       logic [9:0] idx);
    note_cmd_t c;
    c = {op, ts, st, d1, d2, len, idx};
    return c;
  endfunction

  function automatic note_result_t mk_res(logic [1:0] status, logic rev, logic [10:0] count);
    note_result_t r;
    r        = '0;
    r.status = status;
    r.rev    = rev;
    r.count  = count;
    return r;
  endfunction

  // Random command of the given kind; unused fields carry random content
  function automatic note_cmd_t op_cmd(logic [1:0] op);
    note_cmd_t c;
    logic [63:0] wide;
    logic [31:0] bits;
    wide  = {$urandom, $urandom};
    bits  = $urandom;
    c.cmd = op;
    c.ts  = wide[47:0];
    c.st  = bits[7:0];
    c.d1  = bits[15:8];
    c.d2  = bits[23:16];
    c.len = bits[25:24];
    c.idx = wide[57:48];
    return c;
  endfunction

  // Append biased toward note-on/off on a few channels and notes, so pairs form
  function automatic note_cmd_t note_append();
    note_cmd_t c;
    logic [31:0] r;
    logic [7:0] kind;
    logic [3:0] chan;
    c = op_cmd(mnpr_pkg::CMD_APPEND);
    r = $urandom;
    if (r[3:0] < 4'd6) kind = mnpr_pkg::KIND_NOTE_ON;
    else if (r[3:0] < 4'd12) kind = mnpr_pkg::KIND_NOTE_OFF;
    else kind = {r[7:4], 4'h0};
    chan = (r[9:8] != 2'd0) ? {2'b00, r[11:10]} : r[15:12];
    c.st = kind | {4'h0, chan};
    if (r[18:16] != 3'd0) c.d1 = {r[19], 7'd60 + {5'd0, r[21:20]}};
    if (r[23:22] != 2'd0) c.len = 2'd3;
    if (r[26:24] == 3'd0) c.d2 = 8'h00;
    return c;
  endfunction

  // Read near the filled range most of the time, anywhere otherwise
  function automatic note_cmd_t read_cmd();
    note_cmd_t c;
    c = op_cmd(mnpr_pkg::CMD_READ);
    if ($urandom_range(0, 3) != 0) c.idx = 10'($urandom_range(0, shadow_count));
    return c;
  endfunction

  function automatic string describe(note_result_t r);
    return $sformatf("code=%0d ts=%h ev=%h/%h/%h len=%0d swap=%0d dup=%0d orphan=%0d rev=%0d n=%0d",
                     r.status, r.ts, r.st, r.d1, r.d2, r.len, r.swaps, r.dups, r.orphans,
                     r.rev, r.count);
  endfunction

  // Present one command beat after a random gap and log its expected result
  task automatic drive_command(note_cmd_t c, logic has_exp, note_result_t fixed_res);
    int gap;
    note_result_t want;
    gap = calm ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    cmd         <= c.cmd;
    timestamp   <= c.ts;
    status_byte <= c.st;
    data_one    <= c.d1;
    data_two    <= c.d2;
    msg_len     <= c.len;
    entry_index <= c.idx;
    do @(posedge clk); while (!(in_valid && in_ready === 1'b1));
    want = apply_command(c);
    due_results.insert(due_results.size(), has_exp ? fixed_res : want);
  endtask

  task automatic check_result(note_result_t got);
    note_result_t want;
    if (due_results.size() == 0) begin
      mismatch_count++;
      if (mismatch_count <= 10) $display("result beat with nothing expected: %s", describe(got));
    end else begin
      want = due_results.pop_front();
      if (got.status !== want.status || got.ts !== want.ts || got.st !== want.st ||
          got.d1 !== want.d1 || got.d2 !== want.d2 || got.len !== want.len ||
          got.swaps !== want.swaps || got.dups !== want.dups ||
          got.orphans !== want.orphans || got.rev !== want.rev ||
          got.count !== want.count) begin
        mismatch_count++;
        if (mismatch_count <= 10) begin
          $display("mismatch: expected %s", describe(want));
          $display("          actual   %s", describe(got));
        end
      end
    end
  endtask

  // Result side: stall a random number of cycles per beat, then take it
  initial begin
    int stall;
    note_result_t got;
    @(posedge clk);
    forever begin
      stall = calm ? 0 : $urandom_range(0, 11);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(rst === 1'b0 && out_valid === 1'b1 && out_ready === 1'b1));
      got = {status_code, ev_timestamp, ev_status, ev_data_one, ev_data_two, ev_len,
             swap_count, dup_on_count, orphan_off_count, is_reversed, entry_count};
      check_result(got);
    end
  end

  // Watchdog: end the run when no beat moves for too long
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid === 1'b1 && in_ready === 1'b1) ||
          (out_valid === 1'b1 && out_ready === 1'b1)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("FAILURE");
    $finish;
  end

  // Stimulus
  initial begin
    dir_row_t rows [$];
    int random_items;
    int k;
    int pick;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Empty store cases, then a store holding pairs, duplicates, orphans and odd lengths
    rows.insert(rows.size(), {mk_cmd(mnpr_pkg::CMD_REVERSE, '0, '0, '0, '0, '0, '0), 1'b1,
                              mk_res(mnpr_pkg::STAT_EMPTY, 1'b0, 11'd0)});
    rows.insert(rows.size(), {mk_cmd(mnpr_pkg::CMD_READ, '0, '0, '0, '0, '0, 10'd0), 1'b1,
                              mk_res(mnpr_pkg::STAT_RANGE, 1'b0, 11'd0)});
    rows.insert(rows.size(), {mk_cmd(mnpr_pkg::CMD_CLEAR, '0, '0, '0, '0, '0, '0), 1'b1,
                              mk_res(mnpr_pkg::STAT_OK, 1'b0, 11'd0)});
    rows.insert(rows.size(), {mk_cmd(mnpr_pkg::CMD_APPEND, 48'hFFFF_FFFF_FFFF, 8'h90, 8'h3C,
                                     8'h00, 2'd3, 10'h3FF),
                              1'b1, mk_res(mnpr_pkg::STAT_OK, 1'b0, 11'd1)});
    rows.insert(rows.size(), {mk_cmd(mnpr_pkg::CMD_APPEND, 48'd1, 8'h90, 8'h3C, 8'h7F, 2'd3, '0),
                              1'b1, mk_res(mnpr_pkg::STAT_OK, 1'b0, 11'd2)});
    rows.insert(rows.size(), {mk_cmd(mnpr_pkg::CMD_APPEND, 48'd0, 8'h80, 8'h3C, 8'h40, 2'd3, '0),
                              1'b1, mk_res(mnpr_pkg::STAT_OK, 1'b0, 11'd3)});
    rows.insert(rows.size(), {mk_cmd(mnpr_pkg::CMD_APPEND, 48'd2, 8'h80, 8'h3C, 8'h00, 2'd3, '0),
                              1'b1, mk_res(mnpr_pkg::STAT_OK, 1'b0, 11'd4)});
    rows.insert(rows.size(), {mk_cmd(mnpr_pkg::CMD_APPEND, 48'h8000_0000_0000, 8'h9F, 8'hFF,
                                     8'h55, 2'd0, '0),
                              1'b1, mk_res(mnpr_pkg::STAT_OK, 1'b0, 11'd5)});
    rows.insert(rows.size(), {mk_cmd(mnpr_pkg::CMD_APPEND, 48'h0000_0000_00FF, 8'h8F, 8'h12,
                                     8'h34, 2'd1, '0),
                              1'b1, mk_res(mnpr_pkg::STAT_OK, 1'b0, 11'd6)});
    rows.insert(rows.size(), {mk_cmd(mnpr_pkg::CMD_APPEND, 48'h5555_5555_5555, 8'h95, 8'hC5,
                                     8'hAA, 2'd2, '0),
                              1'b1, mk_res(mnpr_pkg::STAT_OK, 1'b0, 11'd7)});
    rows.insert(rows.size(), {mk_cmd(mnpr_pkg::CMD_APPEND, 48'hAAAA_AAAA_AAAA, 8'h85, 8'h45,
                                     8'h00, 2'd3, '0),
                              1'b1, mk_res(mnpr_pkg::STAT_OK, 1'b0, 11'd8)});
    rows.insert(rows.size(), {mk_cmd(mnpr_pkg::CMD_APPEND, 48'h1234_5678_9ABC, 8'hF0, 8'hFF,
                                     8'hFF, 2'd3, '0),
                              1'b1, mk_res(mnpr_pkg::STAT_OK, 1'b0, 11'd9)});
    rows.insert(rows.size(), {mk_cmd(mnpr_pkg::CMD_READ, '0, '0, '0, '0, '0, 10'd0), 1'b0,
                              NO_RESULT});
    rows.insert(rows.size(), {mk_cmd(mnpr_pkg::CMD_REVERSE, '0, '0, '0, '0, '0, '0), 1'b0,
                              NO_RESULT});
    rows.insert(rows.size(), {mk_cmd(mnpr_pkg::CMD_READ, '0, '0, '0, '0, '0, 10'd2), 1'b0,
                              NO_RESULT});
    rows.insert(rows.size(), {mk_cmd(mnpr_pkg::CMD_READ, '1, '1, '1, '1, '1, 10'h3FF), 1'b1,
                              mk_res(mnpr_pkg::STAT_RANGE, 1'b1, 11'd9)});
    rows.insert(rows.size(), {mk_cmd(mnpr_pkg::CMD_REVERSE, '0, '0, '0, '0, '0, '0), 1'b0,
                              NO_RESULT});
    rows.insert(rows.size(), {mk_cmd(mnpr_pkg::CMD_READ, '0, '0, '0, '0, '0, 10'd5), 1'b0,
                              NO_RESULT});
    rows.insert(rows.size(), {mk_cmd(mnpr_pkg::CMD_READ, '0, '0, '0, '0, '0, 10'd8), 1'b0,
                              NO_RESULT});
    rows.insert(rows.size(), {mk_cmd(mnpr_pkg::CMD_CLEAR, '0, '0, '0, '0, '0, '0), 1'b1,
                              mk_res(mnpr_pkg::STAT_OK, 1'b0, 11'd0)});
    for (k = 0; k < rows.size(); k++) drive_command(rows[k].c, rows[k].has_exp, rows[k].r);

    // Random segments: build a small store, then reverse, read and append to it; sometimes random commands
    random_items = 0;
    while (random_items < RANDOM_ITEMS) begin
      calm = ($urandom_range(0, 5) == 0);
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 4)) begin
          drive_command(op_cmd(2'($urandom_range(0, 3))), 1'b0, NO_RESULT);
          random_items++;
        end
      end else begin
        if ($urandom_range(0, 1) == 0) begin
          drive_command(op_cmd(mnpr_pkg::CMD_CLEAR), 1'b0, NO_RESULT);
          random_items++;
        end
        repeat ($urandom_range(1, 8)) begin
          drive_command(note_append(), 1'b0, NO_RESULT);
          random_items++;
        end
        repeat ($urandom_range(3, 8)) begin
          pick = $urandom_range(0, 19);
          if (pick < 11) drive_command(op_cmd(mnpr_pkg::CMD_REVERSE), 1'b0, NO_RESULT);
          else if (pick < 16) drive_command(read_cmd(), 1'b0, NO_RESULT);
          else drive_command(note_append(), 1'b0, NO_RESULT);
          random_items++;
        end
      end
    end

    // Fill the store to capacity, overflow it and walk it both ways
    calm = 1'b0;
    drive_command(op_cmd(mnpr_pkg::CMD_CLEAR), 1'b0, NO_RESULT);
    while (shadow_count < STORE_DEPTH) drive_command(note_append(), 1'b0, NO_RESULT);
    repeat (3) drive_command(note_append(), 1'b0, NO_RESULT);
    drive_command(mk_cmd(mnpr_pkg::CMD_READ, '0, '0, '0, '0, '0, 10'h3FF), 1'b0, NO_RESULT);
    drive_command(mk_cmd(mnpr_pkg::CMD_READ, '0, '0, '0, '0, '0, 10'd0), 1'b0, NO_RESULT);
    drive_command(op_cmd(mnpr_pkg::CMD_REVERSE), 1'b0, NO_RESULT);
    repeat (4) drive_command(read_cmd(), 1'b0, NO_RESULT);
    drive_command(op_cmd(mnpr_pkg::CMD_REVERSE), 1'b0, NO_RESULT);
    drive_command(note_append(), 1'b0, NO_RESULT);
    repeat (4) drive_command(read_cmd(), 1'b0, NO_RESULT);
    drive_command(op_cmd(mnpr_pkg::CMD_CLEAR), 1'b0, NO_RESULT);
    in_valid <= 1'b0;

    // Drain outstanding beats, then watch for strays
    while (due_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && due_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
